>>> design/tmcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmcf_pkg;

    // Samples per averaging window (3 .. 64)
    localparam int SAMPLE_COUNT = 10;

    localparam int CODE_W  = 12;
    localparam int GAIN_W  = 16;
    localparam int MEAN_W  = 20;
    localparam int CUR_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int CNT_W   = $clog2(SAMPLE_COUNT + 1);
    localparam int SUM_W   = $clog2(SAMPLE_COUNT * ((1 << CODE_W) - 1) + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'd1;

    localparam logic [CODE_W-1:0] THRESHOLD_RST = 12'd0;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd3716;

    // Mean divide by (SAMPLE_COUNT - 2) done as multiply by reciprocal.
    // floor(x / D) == (x * ceil(2^S / D)) >> S for x < 2^(S - clog2(D)).
    // The dividend is trimmed << 8, so the shift absorbs the Q8 scaling.
    localparam int MEAN_DIV    = SAMPLE_COUNT - 2;
    localparam int DIV_SHIFT   = SUM_W + FRAC_W + $clog2(MEAN_DIV);
    localparam int DIV_MULT_W  = SUM_W + FRAC_W + 1;
    localparam longint unsigned DIV_MULT_L =
        ((longint'(1) << DIV_SHIFT) + longint'(MEAN_DIV) - 1) / longint'(MEAN_DIV);
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(DIV_MULT_L);
    localparam int MEAN_PROD_W = SUM_W + DIV_MULT_W;
    localparam int MEAN_SHIFT  = DIV_SHIFT - FRAC_W;

    localparam int CUR_PROD_W  = MEAN_W + GAIN_W;

    // Request from the window accumulator to the result pipeline
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] trimmed;
    } trim_req_t;

endpackage

`default_nettype wire

>>> design/tmcf_result_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module tmcf_result_pipe
    import tmcf_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  trim_req_t             req,
    input  wire  [CODE_W-1:0]     threshold,
    input  wire  [GAIN_W-1:0]     gain,
    output logic                  advance,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata     // [19:0] trimmed_mean_q8, [35:20] current_value
);

    logic                    mean_valid_reg;
    logic [MEAN_W-1:0]       mean_reg;
    logic                    diff_valid_reg;
    logic [MEAN_W-1:0]       diff_mean_reg;
    logic [MEAN_W-1:0]       diff_reg;
    logic                    prod_valid_reg;
    logic [MEAN_W-1:0]       prod_mean_reg;
    logic [CUR_PROD_W-1:0]   prod_reg;
    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;

    logic [MEAN_PROD_W-1:0]  mean_prod;
    logic [MEAN_W-1:0]       mean_next;
    logic [MEAN_W-1:0]       thr_q8;
    logic [MEAN_W-1:0]       diff_next;
    logic [CUR_PROD_W-1:0]   prod_next;
    logic [CUR_W-1:0]        cur_next;

    // whole pipe moves when the output slot is free or being taken
    assign advance = !out_valid_reg || m_tready;

    assign mean_prod = MEAN_PROD_W'(req.trimmed) * MEAN_PROD_W'(DIV_MULT);
    assign mean_next = mean_prod[MEAN_SHIFT +: MEAN_W];

    assign thr_q8    = {threshold, {FRAC_W{1'b0}}};
    assign diff_next = (mean_reg > thr_q8) ? (mean_reg - thr_q8) : '0;

    assign prod_next = CUR_PROD_W'(diff_reg) * CUR_PROD_W'(gain);

    // >> 16 then clamp to 16 bits
    assign cur_next = (|prod_reg[CUR_PROD_W-1:2*CUR_W]) ? {CUR_W{1'b1}}
                                                        : prod_reg[2*CUR_W-1:CUR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_valid_reg <= 1'b0;
            diff_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (advance) begin
            mean_valid_reg <= req.valid;
            diff_valid_reg <= mean_valid_reg;
            prod_valid_reg <= diff_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mean_reg      <= mean_next;
            diff_mean_reg <= mean_reg;
            diff_reg      <= diff_next;
            prod_mean_reg <= diff_mean_reg;
            prod_reg      <= prod_next;
            out_data_reg  <= {{(M_TDATA_W - MEAN_W - CUR_W){1'b0}}, cur_next, prod_mean_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> design/trimmed_mean_current_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Trimmed-mean current filter.
// s_ channel: one 12-bit ADC code per transaction. Codes below the no-load
// threshold are dropped; the others build a running sum, max and min.
// Once SAMPLE_COUNT codes are in, the window is closed and the next
// transaction's sample is ignored; that transaction produces exactly one
// m_ transaction: trimmed mean (sum - max - min) / (SAMPLE_COUNT - 2) in Q8
// and the current ((mean - threshold) * gain) >> 16, clamped to 16 bits.
// Then a new window starts.
// Throughput: one s_ transaction per cycle while s_tready is high; the
// accumulator updates in the cycle of acceptance. From the closing
// transaction to m_tvalid the window passes the trim register, reciprocal
// multiply for the divide, threshold subtract, gain multiply and clamp/output register.
// A stalled m_tready freezes the whole result pipeline and drops s_tready
// (combinationally) once the output register is full.
// cfg channel: cfg_index 0 = no-load threshold (12 bit), 1 = gain Q8
// (16 bit); always ready; write only while no result is pending.
// Reset (aresetn low, synchronous): empty window, threshold 0, gain 3716,
// no result pending.
module trimmed_mean_current_filter
    import tmcf_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [S_TDATA_W-1:0]  s_tdata,    // [11:0] sample_code
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [19:0] trimmed_mean_q8, [35:20] current_value
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DAT_W-1:0]  cfg_data
);

    typedef enum logic {
        PH_COLLECT,
        PH_HELD
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [SUM_W-1:0]   sum_reg,    sum_next;
    logic [CODE_W-1:0]  max_reg,    max_next;
    logic [CODE_W-1:0]  min_reg,    min_next;
    trim_req_t          req_reg,    req_next;
    logic [CODE_W-1:0]  threshold_reg;
    logic [GAIN_W-1:0]  gain_reg;

    logic               advance;
    logic               in_fire;
    logic [CODE_W-1:0]  code;

    assign s_tready  = advance;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign code      = s_tdata[CODE_W-1:0];

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            gain_reg      <= GAIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[CODE_W-1:0];
                REG_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // window accumulator
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        req_next   = '{valid: 1'b0, trimmed: sum_reg - SUM_W'(max_reg) - SUM_W'(min_reg)};
        if (in_fire) begin
            case (phase_reg)
                PH_HELD: begin
                    // closing transaction: sample ignored, hand the window to the pipe
                    req_next.valid = 1'b1;
                    phase_next     = PH_COLLECT;
                    count_next     = '0;
                    sum_next       = '0;
                    max_next       = '0;
                    min_next       = {CODE_W{1'b1}};
                end
                default: begin
                    if (code >= threshold_reg) begin
                        sum_next   = sum_reg + SUM_W'(code);
                        count_next = count_reg + CNT_W'(1);
                        if (code > max_reg) max_next = code;
                        if (code < min_reg) min_next = code;
                    end
                    if (count_next >= CNT_W'(SAMPLE_COUNT)) begin
                        phase_next = PH_HELD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_COLLECT;
            count_reg     <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= {CODE_W{1'b1}};
            req_reg.valid <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            if (advance) begin
                req_reg <= req_next;
            end
        end
    end

    tmcf_result_pipe u_result_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req_reg),
        .threshold (threshold_reg),
        .gain      (gain_reg),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a closed window always holds exactly SAMPLE_COUNT codes
    a_held_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HELD |-> count_reg == CNT_W'(SAMPLE_COUNT))
        else $error("closed window with wrong sample count");

    // once anything was accumulated the extremes are ordered
    a_extremes: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> min_reg <= max_reg)
        else $error("running min above running max");

    // an empty window has a zero sum
    a_empty_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> sum_reg == '0)
        else $error("empty window with nonzero sum");

    // closing transaction hands a request to the result pipe
    a_close_req: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && phase_reg == PH_HELD |=> req_reg.valid && phase_reg == PH_COLLECT)
        else $error("closing transaction lost");

endmodule

`default_nettype wire
